// ===== rtl/core/bfst_pkg.sv =====
`timescale 1ns / 1ps

package bfst_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_HEADER_BYTE     = 2'd0;
  localparam logic [1:0] REG_BIT_TIME_US     = 2'd1;
  localparam logic [1:0] REG_FRAME_GAP_US    = 2'd2;
  localparam logic [1:0] REG_STARTUP_WAIT_US = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Reset values of the registers
  localparam logic [7:0]  HEADER_BYTE_RST     = 8'h5A;
  localparam logic [7:0]  BIT_TIME_US_RST     = 8'd10;
  localparam logic [15:0] FRAME_GAP_US_RST    = 16'd2000;
  localparam logic [19:0] STARTUP_WAIT_US_RST = 20'd50000;

  localparam logic [19:0] WAIT_COUNT_MAX = 20'hFFFFF;

  // Stream payload widths (byte padded)
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [1:0] {
    MODE_STARTUP  = 2'd0,
    MODE_OVERRIDE = 2'd1,
    MODE_LINK     = 2'd2
  } mode_t;

  typedef struct packed {
    logic [19:0] startup_wait_us;
    logic [15:0] frame_gap_us;
    logic [7:0]  bit_time_us;
    logic [7:0]  header_byte;
  } cfg_t;

  typedef struct packed {
    logic frame_busy;
    logic override_on;
    logic line_drive;
    logic line_level;
  } line_out_t;

endpackage

// ===== rtl/core/button_frame_serial_transmitter.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Payload (low bit first)
// in_     | slave     | tdata: buttons[7:0], host_connected[8], lines_high[9], zero[15:10]
// out_    | master    | tdata: line_level[0], line_drive[1], override_on[2], frame_busy[3],
//         |           |        zero[7:4]
// cfg_    | write     | cfg_index selects register, cfg_wdata low bits hold the value
//
// One tick per cycle: a tick transfer runs one pass of the mode and shifter
// logic and its result is loaded into the output register at the same edge.
// in_tready is high while the output register is empty or being drained, so
// ticks stream back to back; a stalled result holds the input off.
// Synchronous reset restores register defaults, startup mode, empty output.

module button_frame_serial_transmitter #(
  parameter int FRAME_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // buttons[7:0], host_connected[8], lines_high[9]
  input  logic [bfst_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // line_level[0], line_drive[1], override_on[2], frame_busy[3]
  output logic [bfst_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_wen,
  input  logic [bfst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bfst_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  bfst_pkg::cfg_t       cfg_r;
  bfst_pkg::line_out_t  res;
  logic [bfst_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                 out_tvalid_r;
  logic                 in_xfer;

  assign in_tready  = !out_tvalid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte     <= bfst_pkg::HEADER_BYTE_RST;
      cfg_r.bit_time_us     <= bfst_pkg::BIT_TIME_US_RST;
      cfg_r.frame_gap_us    <= bfst_pkg::FRAME_GAP_US_RST;
      cfg_r.startup_wait_us <= bfst_pkg::STARTUP_WAIT_US_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        bfst_pkg::REG_HEADER_BYTE:     cfg_r.header_byte     <= cfg_wdata[7:0];
        bfst_pkg::REG_BIT_TIME_US:     cfg_r.bit_time_us     <= cfg_wdata[7:0];
        bfst_pkg::REG_FRAME_GAP_US:    cfg_r.frame_gap_us    <= cfg_wdata[15:0];
        bfst_pkg::REG_STARTUP_WAIT_US: cfg_r.startup_wait_us <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  bfst_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (in_xfer),
    .buttons        (in_tdata[7:0]),
    .host_connected (in_tdata[8]),
    .lines_high     (in_tdata[9]),
    .cfg            (cfg_r),
    .res            (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_xfer) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_tdata_r <= {4'd0, res.frame_busy, res.override_on, res.line_drive,
                      res.line_level};
    end
  end

endmodule

// ===== rtl/core/bfst_core.sv =====
`timescale 1ns / 1ps

module bfst_core #(
  parameter int FRAME_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic [7:0]         buttons,
  input  logic               host_connected,
  input  logic               lines_high,
  input  bfst_pkg::cfg_t     cfg,
  output bfst_pkg::line_out_t res
);

  localparam int BL_W = $clog2(FRAME_BITS + 1);

  bfst_pkg::mode_t        mode_r, mode_nxt, mode_a;
  logic [19:0]            wait_count_r, wait_count_nxt;
  logic [FRAME_BITS-1:0]  shift_word_r, shift_word_nxt;
  logic [BL_W-1:0]        bits_left_r, bits_left_nxt;
  logic [7:0]             bit_timer_r, bit_timer_nxt;
  logic [15:0]            gap_timer_r, gap_timer_nxt;

  logic [FRAME_BITS-1:0]  frame_word;
  logic [FRAME_BITS-1:0]  sw;
  logic [BL_W-1:0]        bl, bl_dec;
  logic [7:0]             bt, bt_dec, period;
  logic                   start;

  assign period = (cfg.bit_time_us == 8'd0) ? 8'd1 : cfg.bit_time_us;
  assign frame_word = (FRAME_BITS'(cfg.header_byte) << (FRAME_BITS - 8)) |
                      FRAME_BITS'(buttons);

  // One tick: startup check, link check, then frame shifter
  always_comb begin
    mode_a         = mode_r;
    mode_nxt       = mode_r;
    wait_count_nxt = wait_count_r;
    shift_word_nxt = shift_word_r;
    bits_left_nxt  = bits_left_r;
    bit_timer_nxt  = bit_timer_r;
    gap_timer_nxt  = gap_timer_r;
    start          = 1'b0;
    sw             = shift_word_r;
    bl             = bits_left_r;
    bt             = bit_timer_r;
    bt_dec         = 8'd0;
    bl_dec         = '0;
    res            = '{frame_busy: 1'b0, override_on: 1'b0, line_drive: 1'b0,
                       line_level: 1'b1};

    if (mode_r == bfst_pkg::MODE_STARTUP) begin
      if ((wait_count_r > cfg.startup_wait_us) && !host_connected) begin
        mode_a         = bfst_pkg::MODE_OVERRIDE;
        wait_count_nxt = 20'd0;
      end else if (wait_count_r != bfst_pkg::WAIT_COUNT_MAX) begin
        wait_count_nxt = wait_count_r + 20'd1;
      end
    end

    if (mode_a == bfst_pkg::MODE_OVERRIDE && lines_high) begin
      mode_nxt = bfst_pkg::MODE_LINK;
    end else begin
      mode_nxt = mode_a;
    end

    if (mode_nxt == bfst_pkg::MODE_LINK) begin
      start = (bits_left_r == '0) && (gap_timer_r == 16'd0);
      if (start) begin
        sw = frame_word;
        bl = BL_W'(FRAME_BITS);
        bt = period;
      end
      shift_word_nxt = sw;
      bits_left_nxt  = bl;
      bit_timer_nxt  = bt;
      if (bl != '0) begin
        res.line_level = sw[FRAME_BITS-1];
        res.frame_busy = 1'b1;
        bt_dec = (bt != 8'd0) ? bt - 8'd1 : 8'd0;
        bl_dec = bl - BL_W'(1);
        bit_timer_nxt = bt_dec;
        if (bt_dec == 8'd0) begin
          shift_word_nxt = sw << 1;
          bits_left_nxt  = bl_dec;
          bit_timer_nxt  = period;
          if (bl_dec == '0) begin
            gap_timer_nxt = cfg.frame_gap_us;
          end
        end
      end else begin
        gap_timer_nxt = gap_timer_r - 16'd1;
      end
    end

    res.line_drive  = (mode_nxt == bfst_pkg::MODE_LINK);
    res.override_on = (mode_nxt != bfst_pkg::MODE_STARTUP);
  end

  // State registers advance once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= bfst_pkg::MODE_STARTUP;
      wait_count_r <= 20'd0;
      shift_word_r <= '1;
      bits_left_r  <= '0;
      bit_timer_r  <= 8'd0;
      gap_timer_r  <= 16'd0;
    end else if (adv) begin
      mode_r       <= mode_nxt;
      wait_count_r <= wait_count_nxt;
      shift_word_r <= shift_word_nxt;
      bits_left_r  <= bits_left_nxt;
      bit_timer_r  <= bit_timer_nxt;
      gap_timer_r  <= gap_timer_nxt;
    end
  end

  // Once the line is taken over, startup never comes back
  a_no_return: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != bfst_pkg::MODE_STARTUP) |=> (mode_r != bfst_pkg::MODE_STARTUP))
    else $error("mode fell back to startup");

  // Link mode is sticky
  a_link_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == bfst_pkg::MODE_LINK) |=> (mode_r == bfst_pkg::MODE_LINK))
    else $error("link mode left");

  // Gap timer only runs between frames
  a_gap_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (bits_left_r != '0) |-> (gap_timer_r == 16'd0))
    else $error("gap timer running during a frame");

  // Startup counter is cleared once override is engaged
  a_wait_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != bfst_pkg::MODE_STARTUP) |-> (wait_count_r == 20'd0))
    else $error("wait counter not cleared after takeover");

  // A frame is only shifted while the drivers are on
  a_busy_drive: assert property (@(posedge clk) disable iff (!rst_n)
    res.frame_busy |-> res.line_drive)
    else $error("frame bit outside link mode");

endmodule

// ===== tb/frame_line_checker.sv =====
`timescale 1ns / 1ps

// Watches the tick, result and register channels of the frame transmitter,
// keeps its own copy of the mode machine and the frame shifter, and compares
// every result transfer with the oldest predicted line state.
module frame_line_checker #(
  parameter int FRAME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [bfst_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [bfst_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_wen,
  input  logic [bfst_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfst_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               fail_count,
  output int                               pending
);

  // Register copies
  logic [7:0]  hdr_byte;
  logic [7:0]  bit_us;
  logic [15:0] gap_us;
  logic [19:0] startup_us;

  // Mode machine and frame shifter
  bfst_pkg::mode_t       mode;
  logic [19:0]           startup_cnt;
  logic [FRAME_BITS-1:0] shifter;
  int unsigned           bits_left;
  logic [7:0]            bit_tmr;
  logic [15:0]           gap_tmr;

  bfst_pkg::line_out_t expected_lines[$];
  int miss_cnt = 0;

  // a zero bit time holds each bit for one tick
  function automatic logic [7:0] bit_ticks();
    return (bit_us == 8'd0) ? 8'd1 : bit_us;
  endfunction

  task automatic note_mismatch(input string field, input int want, input int got);
    miss_cnt++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // One tick: startup check, link check, then the frame logic
  task automatic advance_tick(input logic [7:0] btn, input logic host, input logic lines,
                              output bfst_pkg::line_out_t res);
    res = '0;
    res.line_level = 1'b1;

    if (mode == bfst_pkg::MODE_STARTUP) begin
      if (startup_cnt > startup_us && !host) begin
        mode = bfst_pkg::MODE_OVERRIDE;
        startup_cnt = '0;
      end else if (startup_cnt != bfst_pkg::WAIT_COUNT_MAX) begin
        startup_cnt = startup_cnt + 20'd1;
      end
    end

    if (mode == bfst_pkg::MODE_OVERRIDE && lines) mode = bfst_pkg::MODE_LINK;

    if (mode == bfst_pkg::MODE_LINK) begin
      // load a new frame once the previous one and its gap are done
      if (bits_left == 0 && gap_tmr == 16'd0) begin
        shifter = '0;
        shifter[FRAME_BITS-1 -: 8] = hdr_byte;
        shifter[7:0] = btn;
        bits_left = FRAME_BITS;
        bit_tmr = bit_ticks();
      end
      if (bits_left != 0) begin
        res.line_level = shifter[FRAME_BITS-1];
        res.frame_busy = 1'b1;
        if (bit_tmr != 8'd0) bit_tmr = bit_tmr - 8'd1;
        if (bit_tmr == 8'd0) begin
          shifter = shifter << 1;
          bits_left = bits_left - 1;
          bit_tmr = bit_ticks();
          if (bits_left == 0) gap_tmr = gap_us;
        end
      end else begin
        gap_tmr = gap_tmr - 16'd1;
      end
    end

    res.line_drive  = (mode == bfst_pkg::MODE_LINK);
    res.override_on = (mode != bfst_pkg::MODE_STARTUP);
  endtask

  always @(posedge clk) begin : monitor
    bfst_pkg::line_out_t want;
    bfst_pkg::line_out_t got;
    if (!rst_n) begin
      hdr_byte    = bfst_pkg::HEADER_BYTE_RST;
      bit_us      = bfst_pkg::BIT_TIME_US_RST;
      gap_us      = bfst_pkg::FRAME_GAP_US_RST;
      startup_us  = bfst_pkg::STARTUP_WAIT_US_RST;
      mode        = bfst_pkg::MODE_STARTUP;
      startup_cnt = '0;
      shifter     = '1;
      bits_left   = 0;
      bit_tmr     = '0;
      gap_tmr     = '0;
      expected_lines.delete();
    end else begin
      // register writes
      if (cfg_wen) begin
        case (cfg_index)
          bfst_pkg::REG_HEADER_BYTE:     hdr_byte   = cfg_wdata[7:0];
          bfst_pkg::REG_BIT_TIME_US:     bit_us     = cfg_wdata[7:0];
          bfst_pkg::REG_FRAME_GAP_US:    gap_us     = cfg_wdata[15:0];
          bfst_pkg::REG_STARTUP_WAIT_US: startup_us = cfg_wdata[19:0];
          default: ;
        endcase
      end

      // tick transfer: predict its line state
      if (in_tvalid && in_tready) begin
        advance_tick(in_tdata[7:0], in_tdata[8], in_tdata[9], want);
        expected_lines.push_back(want);
      end

      // result transfer: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (expected_lines.size() == 0) begin
          miss_cnt++;
          $error("result transfer with nothing expected, out_tdata=%h", out_tdata);
        end else begin
          want = expected_lines.pop_front();
          got  = bfst_pkg::line_out_t'(out_tdata[3:0]);
          if (got.line_level != want.line_level)
            note_mismatch("line_level", want.line_level, got.line_level);
          if (got.line_drive != want.line_drive)
            note_mismatch("line_drive", want.line_drive, got.line_drive);
          if (got.override_on != want.override_on)
            note_mismatch("override_on", want.override_on, got.override_on);
          if (got.frame_busy != want.frame_busy)
            note_mismatch("frame_busy", want.frame_busy, got.frame_busy);
          if (out_tdata[bfst_pkg::OUT_TDATA_W-1:4] != '0)
            note_mismatch("pad", 0, int'(out_tdata[bfst_pkg::OUT_TDATA_W-1:4]));
        end
      end
    end
    pending    <= expected_lines.size();
    fail_count <= miss_cnt;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int FRAME_BITS = 32;

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic [bfst_pkg::IN_TDATA_W-1:0]      in_tdata = '0;
  logic                                 in_tvalid = 1'b0;
  logic                                 in_tready;
  logic [bfst_pkg::OUT_TDATA_W-1:0]     out_tdata;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic                                 cfg_wen = 1'b0;
  logic [bfst_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [bfst_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;
  int                                   fail_count;
  int                                   pending;
  bit                                   bubbles_on = 1'b0;
  int                                   stall_left = 0;

  always #4 clk = ~clk;

  button_frame_serial_transmitter #(.FRAME_BITS(FRAME_BITS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  frame_line_checker #(.FRAME_BITS(FRAME_BITS)) line_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!bubbles_on || roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side backpressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // one tick transfer, with an optional idle gap ahead of it
  task automatic send_tick(input logic [7:0] btn, input logic host, input logic lines);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {{(bfst_pkg::IN_TDATA_W-10){1'b0}}, lines, host, btn};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random();
    send_tick(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  // stop ticking and wait for every predicted result to arrive
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // leaves cfg_wen high; the caller lowers it after the last write
  task automatic write_reg(input logic [bfst_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bfst_pkg::CFG_DATA_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  initial begin
    int                              n_items;
    bit                              wrote;
    logic [bfst_pkg::CFG_DATA_W-1:0] v;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    bubbles_on = 1'b1;

    // longest startup wait: no takeover while it is in force
    write_reg(bfst_pkg::REG_STARTUP_WAIT_US, bfst_pkg::WAIT_COUNT_MAX);
    cfg_wen <= 1'b0;
    send_tick(8'hFF, 1'b0, 1'b1);
    send_tick(8'h00, 1'b0, 1'b0);
    send_tick(8'h55, 1'b0, 1'b1);
    send_tick(8'hAA, 1'b0, 1'b0);
    drain();

    // short wait, host present keeps the block in startup past it
    write_reg(bfst_pkg::REG_STARTUP_WAIT_US, 20'd8);
    cfg_wen <= 1'b0;
    repeat (6) send_tick(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    // host gone: takeover, lines still low so override holds
    send_tick(8'h0F, 1'b0, 1'b0);
    repeat (3) send_tick(8'hF0, 1'($urandom_range(0, 1)), 1'b0);
    drain();

    // short gap, header and bit time stay at their reset values
    write_reg(bfst_pkg::REG_FRAME_GAP_US, 20'd4);
    cfg_wen <= 1'b0;
    // both lines high: link mode, frame starts on this very tick
    send_tick(8'h81, 1'b0, 1'b1);
    send_tick(8'h7E, 1'b1, 1'b0);
    repeat (200) send_random();

    // register phases; the last two hit the bit time and gap extremes with no idling
    for (int ph = 0; ph < 16; ph++) begin
      drain();
      if (ph == 14) begin
        bubbles_on = 1'b0;
        write_reg(bfst_pkg::REG_BIT_TIME_US, 20'd255);
        write_reg(bfst_pkg::REG_FRAME_GAP_US, 20'd0);
        write_reg(bfst_pkg::REG_HEADER_BYTE, 20'hFF);
        n_items = 200;
      end else if (ph == 15) begin
        bubbles_on = 1'b0;
        write_reg(bfst_pkg::REG_BIT_TIME_US, 20'd0);
        write_reg(bfst_pkg::REG_FRAME_GAP_US, 20'hFFFF);
        write_reg(bfst_pkg::REG_HEADER_BYTE, 20'h00);
        n_items = 100;
      end else begin
        bubbles_on = ($urandom_range(0, 3) != 0);
        wrote = 1'b0;
        if ($urandom_range(0, 9) < 6) begin
          case ($urandom_range(0, 3))
            0:       v = 20'h00;
            1:       v = 20'hFF;
            default: v = 20'($urandom_range(0, 255));
          endcase
          write_reg(bfst_pkg::REG_HEADER_BYTE, v);
          wrote = 1'b1;
        end
        if ($urandom_range(0, 9) < 6) begin
          case ($urandom_range(0, 9))
            0:       v = 20'd0;
            1, 2:    v = 20'd1;
            default: v = 20'($urandom_range(2, 6));
          endcase
          write_reg(bfst_pkg::REG_BIT_TIME_US, v);
          wrote = 1'b1;
        end
        if ($urandom_range(0, 9) < 6) begin
          v = ($urandom_range(0, 3) == 0) ? 20'd0 : 20'($urandom_range(1, 40));
          write_reg(bfst_pkg::REG_FRAME_GAP_US, v);
          wrote = 1'b1;
        end
        if ($urandom_range(0, 9) < 3) begin
          case ($urandom_range(0, 2))
            0:       v = 20'd0;
            1:       v = bfst_pkg::WAIT_COUNT_MAX;
            default: v = 20'($urandom_range(0, 1048575));
          endcase
          write_reg(bfst_pkg::REG_STARTUP_WAIT_US, v);
          wrote = 1'b1;
        end
        if (!wrote) write_reg(bfst_pkg::REG_HEADER_BYTE, 20'($urandom_range(0, 255)));
        n_items = $urandom_range(60, 140);
      end
      cfg_wen <= 1'b0;
      repeat (n_items) send_random();
    end

    drain();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(20_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
